// ===== rtl/core/totm_pkg.sv =====
// Package for the third-order beam transport map: fixed-point widths, codes,
// conversion constants and the Q.22 product helper.
// No dependencies; the top level refers to it by scoped names.
package totm_pkg;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_TRACK = 1'b1;

	// store layout
	localparam int N_FULL      = 31;
	localparam int N_MIXED     = 8;
	localparam int BASE_U      = 31;
	localparam int BASE_Y      = 62;
	localparam int BASE_V      = 70;
	localparam int STORE_DEPTH = 78;

	// port widths
	localparam int POS_W = 20;
	localparam int ANG_W = 24;
	localparam int IDX_W = 7;
	localparam int VAL_W = 32;

	// monomial width (Q.22, third order stays below 2^26)
	localparam int MW = 28;
	// metres estimate width (|pm| < 2^22)
	localparam int QW = 23;

	typedef logic signed [MW-1:0] mono_t;
	typedef logic signed [QW-1:0] qest_t;

	// um -> m: pm = floor((um*2^16 + 7812) / 15625), estimate by reciprocal
	localparam logic signed [23:0] MET_MUL = 24'sd4398046;
	localparam logic signed [43:0] MET_OFS = 44'sd524254;
	localparam int                 MET_SH  = 20;
	localparam logic signed [36:0] MET_BIAS = 37'sd7812;
	localparam logic signed [36:0] MET_DIV  = 37'sd15625;

	// m -> um
	localparam logic signed [52:0] UM_MUL = 53'sd1000000;
	localparam logic signed [52:0] UM_RND = 53'sd2097152;
	localparam logic signed [31:0] POS_LIM = 32'sd1073741824;

	// round(a*b / 2^22)
	function automatic mono_t mulq(input mono_t a, input mono_t b);
		logic signed [2*MW-1:0] p;
		p = (2*MW)'(a) * (2*MW)'(b) + (2*MW)'(2097152);
		return MW'(p >>> 22);
	endfunction

	// correct a metres estimate by one step and negate it
	function automatic mono_t metres_neg(input logic signed [POS_W-1:0] um,
			input qest_t qe);
		logic signed [36:0] n;
		logic signed [36:0] r;
		qest_t q;
		n = (37'(um) <<< 16) + MET_BIAS;
		r = n - 37'(qe) * MET_DIV;
		priority if (r < 37'sd0) begin
			q = qe - qest_t'(1);
		end else if (r >= MET_DIV) begin
			q = qe + qest_t'(1);
		end else begin
			q = qe;
		end
		return mono_t'(0) - MW'(q);
	endfunction

endpackage

// ===== rtl/core/third_order_beam_transport_map_top.sv =====
// Third-order beam transport map: eleven-stage pipeline from track to result.
// Depends on totm_pkg (widths, codes, conversion constants, mulq).
//
// channel | handshake          | payload
// input   | in_valid, in_stall | action coef_index coef_value x_in y_in u_in v_in delta_in
// output  | out_valid,out_stall| x_out y_out u_out v_out saturated
//
// One item per cycle while the pipeline is not held; a track's result leaves from stage 11.
// A load updates the coefficient store when it reaches stage 5, in order
// with the tracks around it, and yields no result.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears the valid bits and the coefficient store.
module third_order_beam_transport_map_top #(
	parameter int COEF_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic [totm_pkg::IDX_W-1:0]            coef_index,
	input  logic signed [totm_pkg::VAL_W-1:0]     coef_value,
	input  logic signed [totm_pkg::POS_W-1:0]     x_in,
	input  logic signed [totm_pkg::POS_W-1:0]     y_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     u_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     v_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     delta_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [totm_pkg::POS_W-1:0]     x_out,
	output logic signed [totm_pkg::POS_W-1:0]     y_out,
	output logic signed [totm_pkg::ANG_W-1:0]     u_out,
	output logic signed [totm_pkg::ANG_W-1:0]     v_out,
	output logic                                  saturated
);

	localparam int CMW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int PW  = CMW + totm_pkg::MW;
	localparam int AW  = PW + 5;
	localparam int SW  = AW - 24;
	localparam int NW0 = SW + 1;
	localparam int NW  = (NW0 > 33) ? NW0 : 33;
	localparam int PWW = totm_pkg::POS_W;
	localparam int AWW = totm_pkg::ANG_W;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [AW-1:0] acc_t;

	logic en;

	// stage valids
	logic trk_s1, trk_s2, trk_s3, trk_s4, trk_s5, trk_s6, trk_s7, trk_s8;
	logic trk_s9, trk_s10, trk_s11;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;

	// load fields
	logic [totm_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [totm_pkg::VAL_W-1:0] val_s1, val_s2, val_s3, val_s4, val_s5;

	// track fields
	logic signed [PWW-1:0] x_s1, y_s1, x_s2, y_s2;
	logic signed [AWW-1:0] u_s1, v_s1, d_s1, u_s2, v_s2, d_s2;
	totm_pkg::qest_t xq_s2, yq_s2;
	totm_pkg::mono_t xm_s3, ym_s3, um_s3, vm_s3, dm_s3;
	totm_pkg::mono_t xm_s4, ym_s4, um_s4, vm_s4, dm_s4;
	totm_pkg::mono_t xx_s4, xu_s4, xd_s4, uu_s4, ud_s4, dd_s4, yy_s4, yv_s4, vv_s4;
	totm_pkg::mono_t xy_s4, xv_s4, uy_s4, uv_s4, dy_s4, dv_s4;
	totm_pkg::mono_t f_s5 [totm_pkg::N_FULL];
	totm_pkg::mono_t g_s5 [totm_pkg::N_MIXED];
	prod_t px_s6 [totm_pkg::N_FULL];
	prod_t pu_s6 [totm_pkg::N_FULL];
	prod_t py_s6 [totm_pkg::N_MIXED];
	prod_t pv_s6 [totm_pkg::N_MIXED];
	acc_t gx_s7 [8];
	acc_t gu_s7 [8];
	acc_t gy_s7 [2];
	acc_t gv_s7 [2];
	acc_t hx_s8 [2];
	acc_t hu_s8 [2];
	acc_t sy_s8, sv_s8;
	acc_t sx_s9, su_s9, sy_s9, sv_s9;
	logic signed [31:0] cx_s10, cy_s10;
	logic signed [AWW-1:0] uo_s10, vo_s10;
	logic flag_s10;
	logic signed [PWW-1:0] xo_s11, yo_s11;
	logic signed [AWW-1:0] uo_s11, vo_s11;
	logic flag_s11;

	coef_t coef_q [totm_pkg::STORE_DEPTH];

	// whole pipe advances unless a result is held back
	assign en       = !(trk_s11 && out_stall);
	assign in_stall = trk_s11 && out_stall;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_s1 <= 1'b0; trk_s2 <= 1'b0; trk_s3 <= 1'b0; trk_s4 <= 1'b0;
			trk_s5 <= 1'b0; trk_s6 <= 1'b0; trk_s7 <= 1'b0; trk_s8 <= 1'b0;
			trk_s9 <= 1'b0; trk_s10 <= 1'b0; trk_s11 <= 1'b0;
			ld_s1 <= 1'b0; ld_s2 <= 1'b0; ld_s3 <= 1'b0; ld_s4 <= 1'b0;
			ld_s5 <= 1'b0;
		end else if (en) begin
			trk_s1  <= in_valid && (action == totm_pkg::ACT_TRACK);
			ld_s1   <= in_valid && (action == totm_pkg::ACT_LOAD);
			trk_s2  <= trk_s1;  ld_s2 <= ld_s1;
			trk_s3  <= trk_s2;  ld_s3 <= ld_s2;
			trk_s4  <= trk_s3;  ld_s4 <= ld_s3;
			trk_s5  <= trk_s4;  ld_s5 <= ld_s4;
			trk_s6  <= trk_s5;
			trk_s7  <= trk_s6;
			trk_s8  <= trk_s7;
			trk_s9  <= trk_s8;
			trk_s10 <= trk_s9;
			trk_s11 <= trk_s10;
		end
	end

	// coefficient store, written as a load passes stage 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < totm_pkg::STORE_DEPTH; i++) begin
				coef_q[i] <= '0;
			end
		end else if (en && ld_s5) begin
			for (int i = 0; i < totm_pkg::STORE_DEPTH; i++) begin
				if (idx_s5 == totm_pkg::IDX_W'(i)) begin
					coef_q[i] <= COEF_WIDTH'(val_s5);
				end
			end
		end
	end

	// stage 1 -> 2: metres estimate by reciprocal multiply
	logic signed [43:0] xp_c, yp_c;
	assign xp_c = 44'(x_s1) * 44'(totm_pkg::MET_MUL) + totm_pkg::MET_OFS;
	assign yp_c = 44'(y_s1) * 44'(totm_pkg::MET_MUL) + totm_pkg::MET_OFS;

	// estimate narrowed to its field
	function automatic totm_pkg::qest_t QW_CAST(input logic signed [43:0] p);
		logic signed [43:0] s;
		s = p >>> totm_pkg::MET_SH;
		return totm_pkg::qest_t'(s);
	endfunction

	// stage 3 -> 4: second-order terms
	totm_pkg::mono_t xx_c, xu_c, xd_c, uu_c, ud_c, dd_c, yy_c, yv_c, vv_c;
	totm_pkg::mono_t xy_c, xv_c, uy_c, uv_c, dy_c, dv_c;
	always_comb begin
		xx_c = totm_pkg::mulq(xm_s3, xm_s3);
		xu_c = totm_pkg::mulq(xm_s3, um_s3);
		xd_c = totm_pkg::mulq(xm_s3, dm_s3);
		uu_c = totm_pkg::mulq(um_s3, um_s3);
		ud_c = totm_pkg::mulq(um_s3, dm_s3);
		dd_c = totm_pkg::mulq(dm_s3, dm_s3);
		yy_c = totm_pkg::mulq(ym_s3, ym_s3);
		yv_c = totm_pkg::mulq(ym_s3, vm_s3);
		vv_c = totm_pkg::mulq(vm_s3, vm_s3);
		xy_c = totm_pkg::mulq(xm_s3, ym_s3);
		xv_c = totm_pkg::mulq(xm_s3, vm_s3);
		uy_c = totm_pkg::mulq(um_s3, ym_s3);
		uv_c = totm_pkg::mulq(um_s3, vm_s3);
		dy_c = totm_pkg::mulq(dm_s3, ym_s3);
		dv_c = totm_pkg::mulq(dm_s3, vm_s3);
	end

	// stage 4 -> 5: third-order terms and monomial vectors
	totm_pkg::mono_t f_c [totm_pkg::N_FULL];
	totm_pkg::mono_t g_c [totm_pkg::N_MIXED];
	always_comb begin
		f_c[0]  = xm_s4; f_c[1] = um_s4; f_c[2] = dm_s4;
		f_c[3]  = xx_s4; f_c[4] = xu_s4; f_c[5] = xd_s4;
		f_c[6]  = uu_s4; f_c[7] = ud_s4; f_c[8] = dd_s4;
		f_c[9]  = yy_s4; f_c[10] = yv_s4; f_c[11] = vv_s4;
		f_c[12] = totm_pkg::mulq(xx_s4, xm_s4);
		f_c[13] = totm_pkg::mulq(xx_s4, um_s4);
		f_c[14] = totm_pkg::mulq(xx_s4, dm_s4);
		f_c[15] = totm_pkg::mulq(xu_s4, um_s4);
		f_c[16] = totm_pkg::mulq(xu_s4, dm_s4);
		f_c[17] = totm_pkg::mulq(xd_s4, dm_s4);
		f_c[18] = totm_pkg::mulq(xy_s4, ym_s4);
		f_c[19] = totm_pkg::mulq(xy_s4, vm_s4);
		f_c[20] = totm_pkg::mulq(xv_s4, vm_s4);
		f_c[21] = totm_pkg::mulq(uu_s4, um_s4);
		f_c[22] = totm_pkg::mulq(uu_s4, dm_s4);
		f_c[23] = totm_pkg::mulq(ud_s4, dm_s4);
		f_c[24] = totm_pkg::mulq(uy_s4, ym_s4);
		f_c[25] = totm_pkg::mulq(uy_s4, vm_s4);
		f_c[26] = totm_pkg::mulq(uv_s4, vm_s4);
		f_c[27] = totm_pkg::mulq(dd_s4, dm_s4);
		f_c[28] = totm_pkg::mulq(dy_s4, ym_s4);
		f_c[29] = totm_pkg::mulq(dy_s4, vm_s4);
		f_c[30] = totm_pkg::mulq(dv_s4, vm_s4);
		g_c[0] = ym_s4; g_c[1] = vm_s4;
		g_c[2] = xy_s4; g_c[3] = uy_s4; g_c[4] = dy_s4;
		g_c[5] = xv_s4; g_c[6] = uv_s4; g_c[7] = dv_s4;
	end

	// stage 5 -> 6: coefficient products
	prod_t px_c [totm_pkg::N_FULL];
	prod_t pu_c [totm_pkg::N_FULL];
	prod_t py_c [totm_pkg::N_MIXED];
	prod_t pv_c [totm_pkg::N_MIXED];
	always_comb begin
		for (int i = 0; i < totm_pkg::N_FULL; i++) begin
			px_c[i] = PW'($signed(coef_q[i][CMW-1:0])) * PW'(f_s5[i]);
			pu_c[i] = PW'($signed(coef_q[totm_pkg::BASE_U + i][CMW-1:0])) * PW'(f_s5[i]);
		end
		for (int i = 0; i < totm_pkg::N_MIXED; i++) begin
			py_c[i] = PW'($signed(coef_q[totm_pkg::BASE_Y + i][CMW-1:0])) * PW'(g_s5[i]);
			pv_c[i] = PW'($signed(coef_q[totm_pkg::BASE_V + i][CMW-1:0])) * PW'(g_s5[i]);
		end
	end

	// stage 6 -> 7: sums of four
	acc_t gx_c [8];
	acc_t gu_c [8];
	acc_t gy_c [2];
	acc_t gv_c [2];
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			gx_c[k] = '0;
			gu_c[k] = '0;
			for (int j = 0; j < 4; j++) begin
				if (4 * k + j < totm_pkg::N_FULL) begin
					gx_c[k] = gx_c[k] + AW'(px_s6[4 * k + j]);
					gu_c[k] = gu_c[k] + AW'(pu_s6[4 * k + j]);
				end
			end
		end
		for (int k = 0; k < 2; k++) begin
			gy_c[k] = AW'(py_s6[4 * k]) + AW'(py_s6[4 * k + 1])
				+ AW'(py_s6[4 * k + 2]) + AW'(py_s6[4 * k + 3]);
			gv_c[k] = AW'(pv_s6[4 * k]) + AW'(pv_s6[4 * k + 1])
				+ AW'(pv_s6[4 * k + 2]) + AW'(pv_s6[4 * k + 3]);
		end
	end

	// stage 9 -> 10: round, negate, clamp
	acc_t rx_c, ry_c, ru_c, rv_c;
	logic signed [NW-1:0] nx_c, ny_c, nu_c, nv_c;
	logic signed [31:0] cx_c, cy_c;
	logic signed [AWW-1:0] uo_c, vo_c;
	logic fl_c;
	localparam logic signed [NW-1:0] LIM_P = NW'(totm_pkg::POS_LIM);
	localparam logic signed [NW-1:0] LIM_N = -NW'(totm_pkg::POS_LIM);
	localparam logic signed [NW-1:0] ANG_P = NW'(8388607);
	localparam logic signed [NW-1:0] ANG_N = -NW'(8388608);
	always_comb begin
		rx_c = (sx_s9 + AW'(25'sd8388608)) >>> 24;
		ry_c = (sy_s9 + AW'(25'sd8388608)) >>> 24;
		ru_c = (su_s9 + AW'(25'sd8388608)) >>> 24;
		rv_c = (sv_s9 + AW'(25'sd8388608)) >>> 24;
		nx_c = NW'(0) - NW'($signed(rx_c[SW-1:0]));
		ny_c = NW'(0) - NW'($signed(ry_c[SW-1:0]));
		nu_c = NW'(0) - NW'($signed(ru_c[SW-1:0]));
		nv_c = NW'(0) - NW'($signed(rv_c[SW-1:0]));
		fl_c = 1'b0;
		priority if (nx_c > LIM_P) begin
			cx_c = totm_pkg::POS_LIM; fl_c = 1'b1;
		end else if (nx_c < LIM_N) begin
			cx_c = -totm_pkg::POS_LIM; fl_c = 1'b1;
		end else begin
			cx_c = 32'(nx_c);
		end
		priority if (ny_c > LIM_P) begin
			cy_c = totm_pkg::POS_LIM; fl_c = 1'b1;
		end else if (ny_c < LIM_N) begin
			cy_c = -totm_pkg::POS_LIM; fl_c = 1'b1;
		end else begin
			cy_c = 32'(ny_c);
		end
		priority if (nu_c > ANG_P) begin
			uo_c = AWW'(ANG_P); fl_c = 1'b1;
		end else if (nu_c < ANG_N) begin
			uo_c = AWW'(ANG_N); fl_c = 1'b1;
		end else begin
			uo_c = AWW'(nu_c);
		end
		priority if (nv_c > ANG_P) begin
			vo_c = AWW'(ANG_P); fl_c = 1'b1;
		end else if (nv_c < ANG_N) begin
			vo_c = AWW'(ANG_N); fl_c = 1'b1;
		end else begin
			vo_c = AWW'(nv_c);
		end
	end

	// stage 10 -> 11: metres back to micrometres, saturate
	logic signed [52:0] mx_c, my_c;
	logic signed [52:0] ex_c, ey_c;
	logic signed [PWW-1:0] xo_c, yo_c;
	logic fp_c;
	localparam logic signed [52:0] POS_P = 53'sd524287;
	localparam logic signed [52:0] POS_N = -53'sd524288;
	always_comb begin
		mx_c = 53'(cx_s10) * totm_pkg::UM_MUL + totm_pkg::UM_RND;
		my_c = 53'(cy_s10) * totm_pkg::UM_MUL + totm_pkg::UM_RND;
		ex_c = mx_c >>> 22;
		ey_c = my_c >>> 22;
		fp_c = 1'b0;
		priority if (ex_c > POS_P) begin
			xo_c = PWW'(POS_P); fp_c = 1'b1;
		end else if (ex_c < POS_N) begin
			xo_c = PWW'(POS_N); fp_c = 1'b1;
		end else begin
			xo_c = PWW'(ex_c);
		end
		priority if (ey_c > POS_P) begin
			yo_c = PWW'(POS_P); fp_c = 1'b1;
		end else if (ey_c < POS_N) begin
			yo_c = PWW'(POS_N); fp_c = 1'b1;
		end else begin
			yo_c = PWW'(ey_c);
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= coef_index; val_s1 <= coef_value;
			x_s1 <= x_in; y_s1 <= y_in; u_s1 <= u_in; v_s1 <= v_in; d_s1 <= delta_in;

			idx_s2 <= idx_s1; val_s2 <= val_s1;
			x_s2 <= x_s1; y_s2 <= y_s1; u_s2 <= u_s1; v_s2 <= v_s1; d_s2 <= d_s1;
			xq_s2 <= QW_CAST(xp_c);
			yq_s2 <= QW_CAST(yp_c);

			idx_s3 <= idx_s2; val_s3 <= val_s2;
			xm_s3 <= totm_pkg::metres_neg(x_s2, xq_s2);
			ym_s3 <= totm_pkg::metres_neg(y_s2, yq_s2);
			um_s3 <= totm_pkg::mono_t'(0) - totm_pkg::mono_t'(u_s2);
			vm_s3 <= totm_pkg::mono_t'(0) - totm_pkg::mono_t'(v_s2);
			dm_s3 <= totm_pkg::mono_t'(d_s2);

			idx_s4 <= idx_s3; val_s4 <= val_s3;
			xm_s4 <= xm_s3; ym_s4 <= ym_s3; um_s4 <= um_s3; vm_s4 <= vm_s3; dm_s4 <= dm_s3;
			xx_s4 <= xx_c; xu_s4 <= xu_c; xd_s4 <= xd_c; uu_s4 <= uu_c; ud_s4 <= ud_c;
			dd_s4 <= dd_c; yy_s4 <= yy_c; yv_s4 <= yv_c; vv_s4 <= vv_c;
			xy_s4 <= xy_c; xv_s4 <= xv_c; uy_s4 <= uy_c; uv_s4 <= uv_c;
			dy_s4 <= dy_c; dv_s4 <= dv_c;

			idx_s5 <= idx_s4; val_s5 <= val_s4;
			f_s5 <= f_c;
			g_s5 <= g_c;

			px_s6 <= px_c; pu_s6 <= pu_c; py_s6 <= py_c; pv_s6 <= pv_c;

			gx_s7 <= gx_c; gu_s7 <= gu_c; gy_s7 <= gy_c; gv_s7 <= gv_c;

			hx_s8[0] <= gx_s7[0] + gx_s7[1] + gx_s7[2] + gx_s7[3];
			hx_s8[1] <= gx_s7[4] + gx_s7[5] + gx_s7[6] + gx_s7[7];
			hu_s8[0] <= gu_s7[0] + gu_s7[1] + gu_s7[2] + gu_s7[3];
			hu_s8[1] <= gu_s7[4] + gu_s7[5] + gu_s7[6] + gu_s7[7];
			sy_s8 <= gy_s7[0] + gy_s7[1];
			sv_s8 <= gv_s7[0] + gv_s7[1];

			sx_s9 <= hx_s8[0] + hx_s8[1];
			su_s9 <= hu_s8[0] + hu_s8[1];
			sy_s9 <= sy_s8;
			sv_s9 <= sv_s8;

			cx_s10 <= cx_c; cy_s10 <= cy_c;
			uo_s10 <= uo_c; vo_s10 <= vo_c; flag_s10 <= fl_c;

			xo_s11 <= xo_c; yo_s11 <= yo_c;
			uo_s11 <= uo_s10; vo_s11 <= vo_s10;
			flag_s11 <= flag_s10 | fp_c;
		end
	end

	assign out_valid = trk_s11;
	assign x_out     = xo_s11;
	assign y_out     = yo_s11;
	assign u_out     = uo_s11;
	assign v_out     = vo_s11;
	assign saturated = flag_s11;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held back with no result waiting");

	a_frozen_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(trk_s10) && $stable(ld_s5))
		else $error("pipeline moved while held");

	a_load_or_track: assert property (@(posedge clk) disable iff (!arst_n)
		!(ld_s5 && trk_s5))
		else $error("stage 5 holds a load and a track at once");

endmodule

// ===== sim/transport_map_checker.sv =====
// Checker for the third-order beam transport map: watches both channels,
// predicts each track's result from its own copy of the coefficient store.
// Depends on totm_pkg (widths, action codes, store layout).
module transport_map_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  action,
	input  logic [totm_pkg::IDX_W-1:0]            coef_index,
	input  logic signed [totm_pkg::VAL_W-1:0]     coef_value,
	input  logic signed [totm_pkg::POS_W-1:0]     x_in,
	input  logic signed [totm_pkg::POS_W-1:0]     y_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     u_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     v_in,
	input  logic signed [totm_pkg::ANG_W-1:0]     delta_in,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [totm_pkg::POS_W-1:0]     x_out,
	input  logic signed [totm_pkg::POS_W-1:0]     y_out,
	input  logic signed [totm_pkg::ANG_W-1:0]     u_out,
	input  logic signed [totm_pkg::ANG_W-1:0]     v_out,
	input  logic                                  saturated,
	output int                                    fail_count,
	output int                                    pending_tracks
);
	timeunit 1ns;
	timeprecision 1ps;
	import totm_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [ANG_W-1:0] u;
		logic signed [ANG_W-1:0] v;
		logic                    sat;
	} track_result_t;

	longint        coef_shadow[STORE_DEPTH];
	track_result_t expected_tracks[$];

	assign pending_tracks = expected_tracks.size();

	function automatic longint shr_round(input longint a, input int s);
		return (a + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint q22_mul(input longint a, input longint b);
		return shr_round(a * b, 22);
	endfunction

	// um -> metres Q.22, floor division
	function automatic longint um_to_m(input longint um);
		longint n;
		n = um * 4194304 + 500000;
		if (n >= 0) return n / 1000000;
		return -((-n + 999999) / 1000000);
	endfunction

	function automatic longint clip(input longint a, input int w, inout bit flag);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		if (a > hi) begin flag = 1; return hi; end
		if (a < lo) begin flag = 1; return lo; end
		return a;
	endfunction

	// coefficient split into Q8 integer and 24-bit fraction parts
	function automatic longint poly_sum(input int base, input longint m[31], input int n);
		longint hi, lo, ch;
		hi = 0;
		lo = 0;
		for (int i = 0; i < n; i++) begin
			ch = coef_shadow[base + i] >>> 24;
			hi += ch * m[i];
			lo += (coef_shadow[base + i] - ch * 16777216) * m[i];
		end
		return hi + shr_round(lo, 24);
	endfunction

	function automatic longint m_to_um(input longint s, inout bit flag);
		longint a;
		a = -s;
		if (a > (longint'(1) << 30)) begin a = longint'(1) << 30; flag = 1; end
		if (a < -(longint'(1) << 30)) begin a = -(longint'(1) << 30); flag = 1; end
		return clip(shr_round(a * 1000000, 22), 20, flag);
	endfunction

	function automatic track_result_t transport_track();
		longint X, Y, U, V, D, xx, xu, xd, uu, ud, dd, yy, yv, vv;
		longint f[31];
		longint g[31];
		bit flag;
		track_result_t r;
		flag = 0;
		X = -um_to_m(x_in);
		Y = -um_to_m(y_in);
		U = -longint'(u_in);
		V = -longint'(v_in);
		D = delta_in;
		xx = q22_mul(X, X); xu = q22_mul(X, U); xd = q22_mul(X, D);
		uu = q22_mul(U, U); ud = q22_mul(U, D); dd = q22_mul(D, D);
		yy = q22_mul(Y, Y); yv = q22_mul(Y, V); vv = q22_mul(V, V);
		f[0] = X; f[1] = U; f[2] = D;
		f[3] = xx; f[4] = xu; f[5] = xd; f[6] = uu; f[7] = ud; f[8] = dd;
		f[9] = yy; f[10] = yv; f[11] = vv;
		f[12] = q22_mul(xx, X); f[13] = q22_mul(xx, U); f[14] = q22_mul(xx, D);
		f[15] = q22_mul(xu, U); f[16] = q22_mul(xu, D); f[17] = q22_mul(xd, D);
		f[18] = q22_mul(q22_mul(X, Y), Y); f[19] = q22_mul(q22_mul(X, Y), V);
		f[20] = q22_mul(q22_mul(X, V), V);
		f[21] = q22_mul(uu, U); f[22] = q22_mul(uu, D); f[23] = q22_mul(ud, D);
		f[24] = q22_mul(q22_mul(U, Y), Y); f[25] = q22_mul(q22_mul(U, Y), V);
		f[26] = q22_mul(q22_mul(U, V), V);
		f[27] = q22_mul(dd, D);
		f[28] = q22_mul(q22_mul(D, Y), Y); f[29] = q22_mul(q22_mul(D, Y), V);
		f[30] = q22_mul(q22_mul(D, V), V);
		foreach (g[i]) g[i] = 0;
		g[0] = Y; g[1] = V;
		g[2] = q22_mul(Y, X); g[3] = q22_mul(Y, U); g[4] = q22_mul(Y, D);
		g[5] = q22_mul(V, X); g[6] = q22_mul(V, U); g[7] = q22_mul(V, D);
		r.x = POS_W'(m_to_um(poly_sum(0, f, N_FULL), flag));
		r.y = POS_W'(m_to_um(poly_sum(BASE_Y, g, N_MIXED), flag));
		r.u = ANG_W'(clip(-poly_sum(BASE_U, f, N_FULL), 24, flag));
		r.v = ANG_W'(clip(-poly_sum(BASE_V, g, N_MIXED), 24, flag));
		r.sat = flag;
		return r;
	endfunction

	// input transfers: loads update the shadow store, tracks queue a result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (coef_shadow[i]) coef_shadow[i] = 0;
			expected_tracks.delete();
		end else if (in_valid && !in_stall) begin
			if (action == ACT_LOAD) begin
				if (coef_index < STORE_DEPTH)
					coef_shadow[coef_index] = coef_value;
			end else begin
				expected_tracks.insert(expected_tracks.size(), transport_track());
			end
		end
	end

	// output transfers against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		track_result_t e;
		if (!arst_n) begin
			fail_count = 0;
		end else if (out_valid && !out_stall) begin
			#0;
			if (expected_tracks.size() == 0) begin
				$error("result with no track outstanding");
				fail_count++;
			end else begin
				e = expected_tracks.pop_front();
				if (x_out !== e.x) begin
					$error("x_out expected %0d actual %0d", e.x, x_out);
					fail_count++;
				end
				if (y_out !== e.y) begin
					$error("y_out expected %0d actual %0d", e.y, y_out);
					fail_count++;
				end
				if (u_out !== e.u) begin
					$error("u_out expected %0d actual %0d", e.u, u_out);
					fail_count++;
				end
				if (v_out !== e.v) begin
					$error("v_out expected %0d actual %0d", e.v, v_out);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Stimulus and verdict for the third-order beam transport map.
// Depends on totm_pkg, third_order_beam_transport_map_top, transport_map_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import totm_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_LOAD;
	logic [IDX_W-1:0] coef_index = '0;
	logic signed [VAL_W-1:0] coef_value = '0;
	logic signed [POS_W-1:0] x_in = '0;
	logic signed [POS_W-1:0] y_in = '0;
	logic signed [ANG_W-1:0] u_in = '0;
	logic signed [ANG_W-1:0] v_in = '0;
	logic signed [ANG_W-1:0] delta_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] x_out;
	logic signed [POS_W-1:0] y_out;
	logic signed [ANG_W-1:0] u_out;
	logic signed [ANG_W-1:0] v_out;
	logic saturated;
	int fail_count;
	int pending_tracks;
	int send_idle_pct = 31;
	int recv_idle_pct = 66;
	bit hold_off = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	third_order_beam_transport_map_top i_dut (.*);
	transport_map_checker i_checker (.*);

	// receiver stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// valid stays up between back-to-back transfers and drops only when idling
	task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [ANG_W-1:0] u,
			input logic [ANG_W-1:0] v, input logic [ANG_W-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act; coef_index <= idx; coef_value <= val;
		x_in <= x; y_in <= y; u_in <= u; v_in <= v; delta_in <= d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic load_coef(input int idx, input logic [VAL_W-1:0] val);
		send_item(ACT_LOAD, IDX_W'(idx), val, POS_W'($urandom), POS_W'($urandom),
			ANG_W'($urandom), ANG_W'($urandom), ANG_W'($urandom));
	endtask

	task automatic random_track();
		send_item(ACT_TRACK, IDX_W'($urandom), $urandom, POS_W'($urandom),
			POS_W'($urandom), ANG_W'($urandom), ANG_W'($urandom), ANG_W'($urandom));
	endtask

	// small coefficients most of the time, full range now and then
	function automatic logic [VAL_W-1:0] pick_coef();
		case ($urandom_range(3))
			0: return $urandom;
			1: return VAL_W'(0);
			default: return VAL_W'($signed($urandom_range(33554431)) - 16777216);
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero store, extremes, then full-scale and out-of-range coefficient loads and more tracks
		send_item(ACT_TRACK, '0, '0, 20'h7FFFF, 20'h80000, 24'h7FFFFF, 24'h800000,
			24'h7FFFFF);
		load_coef(0, 32'h7FFFFFFF);
		load_coef(BASE_U + 1, 32'h80000000);
		load_coef(BASE_Y, 32'h01000000);
		load_coef(BASE_V + 1, 32'hFF000000);
		load_coef(STORE_DEPTH - 1, 32'h00800000);
		load_coef(N_FULL - 1, 32'h7FFFFFFF);
		load_coef(120, 32'h12345678);
		load_coef(127, 32'hFFFFFFFF);
		send_item(ACT_TRACK, '0, '0, 20'h7FFFF, 20'h7FFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF);
		send_item(ACT_TRACK, '0, '0, 20'h80000, 20'h80000, 24'h800000, 24'h800000,
			24'h800000);
		send_item(ACT_TRACK, '0, '0, '0, '0, '0, '0, '0);
		send_item(ACT_TRACK, '0, '0, 20'd1000, 20'hFFC18, 24'd4194, 24'hFFEF9E,
			24'd41943);
		for (int i = 0; i < 8; i++) random_track();

		// random phases with changing idling
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin send_idle_pct = 66; recv_idle_pct = 31; end
			if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
			for (int n = 0; n < 330; n++) begin
				if (phase == 2 && n == 100) begin
					fork
						begin
							hold_off = 1;
							repeat (60) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				if ($urandom_range(9) < 2) load_coef($urandom_range(STORE_DEPTH - 1),
					pick_coef());
				else if ($urandom_range(49) == 0) load_coef($urandom_range(127), $urandom);
				else random_track();
			end
		end
		in_valid <= 1'b0;

		while (pending_tracks != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

// ===== third_order_beam_transport_map_top.f =====
rtl/core/totm_pkg.sv
rtl/core/third_order_beam_transport_map_top.sv
sim/transport_map_checker.sv
sim/testbench.sv
